// ===== sv/kmmrt_pkg.sv =====
// Shared types and constants for the keyed min/max range table.
// Used by kmmrt_cell and keyed_min_max_range_table; depends on nothing.
package kmmrt_pkg;

   // Table capacity: one cell per entry.
   localparam int ENTRIES = 32;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 64;

   // Request selector codes (req_tuser).
   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   // Response kind codes (rsp_tuser).
   localparam logic KIND_RANGE    = 1'b0;
   localparam logic KIND_OVERFLOW = 1'b1;

   // Contents of one table entry.
   typedef struct packed {
      logic                      valid;
      logic [KEY_W-1:0]          key;
      logic signed [VALUE_W-1:0] low;
      logic signed [VALUE_W-1:0] high;
   } entry_type;

   // Command broadcast from the controller to every cell.
   typedef struct packed {
      logic                      record;
      logic                      shift;
      logic                      any_hit;
      logic [KEY_W-1:0]          key;
      logic signed [VALUE_W-1:0] value;
   } cmd_type;

   localparam entry_type EMPTY_ENTRY = '{valid: 1'b0, key: '0, low: '0, high: '0};

endpackage

// ===== sv/kmmrt_cell.sv =====
// One cell of the range table chain: holds a single keyed range entry.
// Depends on kmmrt_pkg; instantiated in a row by keyed_min_max_range_table.
module kmmrt_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  kmmrt_pkg::cmd_type   cmd,
   input  logic                 prev_valid,
   input  kmmrt_pkg::entry_type next_entry,
   output kmmrt_pkg::entry_type entry,
   output logic                 hit
);
   import kmmrt_pkg::*;

   logic                      valid_ff, valid_in;
   logic [KEY_W-1:0]          key_ff, key_in;
   logic signed [VALUE_W-1:0] low_ff, low_in;
   logic signed [VALUE_W-1:0] high_ff, high_in;

   // Match the broadcast key against the stored key
   assign hit = valid_ff && (key_ff == cmd.key);

   assign entry = '{valid: valid_ff, key: key_ff, low: low_ff, high: high_ff};

   // Shift toward the head on flush, widen on hit, allocate at the first free cell
   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      if (cmd.shift) begin
         valid_in = next_entry.valid;
         key_in   = next_entry.key;
         low_in   = next_entry.low;
         high_in  = next_entry.high;
      end else if (cmd.record) begin
         if (hit) begin
            if (cmd.value < low_ff) begin
               low_in = cmd.value;
            end else if (cmd.value > high_ff) begin
               high_in = cmd.value;
            end
         end else if (!cmd.any_hit && !valid_ff && prev_valid) begin
            valid_in = 1'b1;
            key_in   = cmd.key;
            low_in   = cmd.value;
            high_in  = cmd.value;
         end
      end
   end

   // Hold the entry; only the valid bit is cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff  <= key_in;
      low_ff  <= low_in;
      high_ff <= high_in;
   end

endmodule

// ===== sv/keyed_min_max_range_table.sv =====
// Keyed min/max range table: top level with a row of kmmrt_cell entries.
// Depends on kmmrt_pkg and kmmrt_cell.
//
// Usage:
//   req_* carries one transaction per item: req_tuser selects record (0) or
//   flush (1); req_tdata carries the key and the signed value.
//   A record folds the value into the range kept under its key. Every cell
//   compares the key at once, so records are taken one per cycle while
//   req_tready is high, with no result, except when the key is new and all
//   ENTRIES cells are used: then one overflow transaction (rsp_tuser = 1,
//   rsp_tlast = 1) is returned the cycle after acceptance; the value is dropped.
//   A flush returns every stored range in fill order, one per cycle while
//   rsp_tready is high, the final one with rsp_tlast = 1, by shifting the
//   cell row toward cell 0; while it runs, req_tready is low. A flush of an
//   empty table returns nothing.
//   Results sit in a single output register; while a result waits there with
//   rsp_tready low, the register holds and no new request or flush step proceeds.
//   Reset (synchronous, active high) empties the table.
module keyed_min_max_range_table (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // [31:0] key, [95:32] value
   input  logic         req_tuser,   // [0] op
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata,   // [31:0] range_key, [95:32] lowest, [159:96] highest
   output logic         rsp_tuser,   // [0] kind
   output logic         rsp_tlast    // last
);
   import kmmrt_pkg::*;

   typedef enum logic {ST_IDLE, ST_FLUSH} state_type;

   state_type state_ff, state_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_kind_ff, rsp_kind_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic [KEY_W-1:0]          rsp_key_ff, rsp_key_in;
   logic signed [VALUE_W-1:0] rsp_low_ff, rsp_low_in;
   logic signed [VALUE_W-1:0] rsp_high_ff, rsp_high_in;

   cmd_type                   cmd;
   entry_type                 cells  [ENTRIES];
   entry_type                 nexts  [ENTRIES];
   logic [ENTRIES-1:0]        hits;
   logic [ENTRIES-1:0]        prevs;

   logic                      out_free;
   logic                      accept;
   logic                      is_flush;
   logic                      full;
   logic [KEY_W-1:0]          req_key;
   logic signed [VALUE_W-1:0] req_value;

   assign req_key   = req_tdata[KEY_W-1:0];
   assign req_value = req_tdata[KEY_W+VALUE_W-1:KEY_W];

   // Output register may take new data when empty or being drained
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign is_flush   = (req_tuser == OP_FLUSH);

   // Broadcast command to the cell row
   assign cmd.record  = accept && !is_flush;
   assign cmd.shift   = (state_ff == ST_FLUSH) && out_free;
   assign cmd.any_hit = |hits;
   assign cmd.key     = req_key;
   assign cmd.value   = req_value;

   // Cells fill from cell 0 upward, so the last cell marks a full table
   assign full = cells[ENTRIES-1].valid;

   // Build the row; each cell sees its neighbors
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign prevs[i] = 1'b1;
      end else begin : g_body
         assign prevs[i] = cells[i-1].valid;
      end
      if (i == ENTRIES - 1) begin : g_tail
         assign nexts[i] = EMPTY_ENTRY;
      end else begin : g_link
         assign nexts[i] = cells[i+1];
      end
      kmmrt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .prev_valid (prevs[i]),
         .next_entry (nexts[i]),
         .entry      (cells[i]),
         .hit        (hits[i])
      );
   end

   // Sequence flush steps and load the output register
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_low_in   = rsp_low_ff;
      rsp_high_in  = rsp_high_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_flush && cells[0].valid) begin
               state_in = ST_FLUSH;
            end
            // Drop a new key when the table is full and report it
            if (cmd.record && !cmd.any_hit && full) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_OVERFLOW;
               rsp_last_in  = 1'b1;
               rsp_key_in   = req_key;
               rsp_low_in   = req_value;
               rsp_high_in  = req_value;
            end
         end
         ST_FLUSH: begin
            if (cmd.shift) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_RANGE;
               rsp_last_in  = !nexts[0].valid;
               rsp_key_in   = cells[0].key;
               rsp_low_in   = cells[0].low;
               rsp_high_in  = cells[0].high;
               if (!nexts[0].valid) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and the output transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_low_ff  <= rsp_low_in;
      rsp_high_ff <= rsp_high_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {rsp_high_ff, rsp_low_ff, rsp_key_ff};

endmodule
